// ===== hdl/ftfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfp_pkg
// Shared constants and types of the force/torque frame parser.
// ----------------------------------------------------------------------------
package ftfp_pkg;

    localparam int CHANNELS     = 6;
    localparam int FRAME_LEN    = 4 * CHANNELS + 4;
    localparam int PAYLOAD_LEN  = 4 * CHANNELS;
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUEUE_DEPTH  = 8;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH) + 1;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  HDR0        = 8'h48;
    localparam logic [7:0]  HDR1        = 8'hAA;
    localparam logic [7:0]  TRL0        = 8'h0D;
    localparam logic [7:0]  TRL1        = 8'h0A;
    localparam logic [31:0] SCALE_RESET = 32'h411C_CCCD;
    localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);
    localparam logic [2:0]  LAST_CHAN   = 3'(CHANNELS - 1);

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_ZERO,
        KIND_INF,
        KIND_NAN
    } kind_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic [2:0] channel;
        logic       last;
    } tag_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [31:0] value;
        logic        last;
    } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/ftfp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfp_cell
// One byte of the receive window: take the neighbor's byte on shift, zero on clear.
// ----------------------------------------------------------------------------
module ftfp_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ftfp_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]          d,
    output logic [7:0]               q
);
    import ftfp_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'h00;
        end
        else if (ctrl.shift)
        begin
            byte_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule
`default_nettype wire

// ===== hdl/ftfp_fmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfp_fmul
// Three-stage IEEE single multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module ftfp_fmul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [31:0]   a,
    input  wire logic [31:0]   b,
    input  wire ftfp_pkg::tag_t in_tag,
    output logic               out_valid,
    output logic [31:0]        result,
    output ftfp_pkg::tag_t     out_tag,
    output logic [1:0]         inflight
);
    import ftfp_pkg::*;

    // stage 1: unpack and multiply mantissas
    logic               v1_reg;
    kind_t              kind1_reg, kind1_next;
    logic               sign1_reg;
    logic signed [10:0] esum1_reg, esum1_next;
    logic [47:0]        p1_reg;
    tag_t               tag1_reg;

    // stage 2: normalize
    logic               v2_reg;
    kind_t              kind2_reg, kind2_next;
    logic               sign2_reg;
    logic signed [10:0] e2_reg, e2_next;
    logic [47:0]        pn2_reg, pn2_next;
    tag_t               tag2_reg;

    // stage 3: denormalize and round
    logic               v3_reg;
    logic [31:0]        res3_reg, res3_next;
    tag_t               tag3_reg;

    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [5:0]  lz;
    logic [47:0] x;
    logic signed [10:0] neg;
    logic [4:0]  amt;
    logic [79:0] ext;
    logic [23:0] m;
    logic        g, st, inc;
    logic [7:0]  expf;
    logic [30:0] mag;

    always_comb
    begin
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        ma = {(ea != 8'd0), fa};
        mb = {(eb != 8'd0), fb};
        a_nan  = (ea == 8'hFF) && (fa != 23'd0);
        b_nan  = (eb == 8'hFF) && (fb != 23'd0);
        a_inf  = (ea == 8'hFF) && (fa == 23'd0);
        b_inf  = (eb == 8'hFF) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            kind1_next = KIND_NAN;
        end
        else if (a_inf || b_inf)
        begin
            kind1_next = KIND_INF;
        end
        else
        begin
            kind1_next = KIND_NUM;
        end
        // subnormal inputs carry an effective exponent of 1
        esum1_next = $signed({3'b000, ((ea == 8'd0) ? 8'd1 : ea)})
                   + $signed({3'b000, ((eb == 8'd0) ? 8'd1 : eb)})
                   - 11'sd126;
    end

    always_ff @(posedge clk)
    begin
        kind1_reg <= kind1_next;
        sign1_reg <= a[31] ^ b[31];
        esum1_reg <= esum1_next;
        p1_reg    <= ma * mb;
        tag1_reg  <= in_tag;
    end

    // leading-zero normalize in six binary steps
    always_comb
    begin
        x  = p1_reg;
        lz = 6'd0;
        if (x[47:16] == 32'd0) begin x = x << 32; lz = lz + 6'd32; end
        if (x[47:32] == 16'd0) begin x = x << 16; lz = lz + 6'd16; end
        if (x[47:40] == 8'd0)  begin x = x << 8;  lz = lz + 6'd8;  end
        if (x[47:44] == 4'd0)  begin x = x << 4;  lz = lz + 6'd4;  end
        if (x[47:46] == 2'd0)  begin x = x << 2;  lz = lz + 6'd2;  end
        if (x[47] == 1'b0)     begin x = x << 1;  lz = lz + 6'd1;  end
        pn2_next = x;
        e2_next  = esum1_reg - $signed({5'd0, lz});
        kind2_next = kind1_reg;
        if ((kind1_reg == KIND_NUM) && (p1_reg == 48'd0))
        begin
            kind2_next = KIND_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        kind2_reg <= kind2_next;
        sign2_reg <= sign1_reg;
        e2_reg    <= e2_next;
        pn2_reg   <= pn2_next;
        tag2_reg  <= tag1_reg;
    end

    always_comb
    begin
        neg = 11'sd1 - e2_reg;
        if (e2_reg >= 11'sd1)
        begin
            amt = 5'd0;
        end
        else if (neg > 11'sd31)
        begin
            amt = 5'd31;
        end
        else
        begin
            amt = neg[4:0];
        end
        ext  = {pn2_reg, 32'd0} >> amt;
        m    = ext[79:56];
        g    = ext[55];
        st   = |ext[54:0];
        inc  = g & (st | m[0]);
        expf = m[23] ? e2_reg[7:0] : 8'd0;
        mag  = {expf, m[22:0]} + {30'd0, inc};
        unique case (kind2_reg)
            KIND_NAN:  res3_next = QNAN_BITS;
            KIND_INF:  res3_next = {sign2_reg, 8'hFF, 23'd0};
            KIND_ZERO: res3_next = {sign2_reg, 31'd0};
            default:
            begin
                if (e2_reg >= 11'sd255)
                begin
                    res3_next = {sign2_reg, 8'hFF, 23'd0};
                end
                else
                begin
                    res3_next = {sign2_reg, mag};
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res3_reg <= res3_next;
        tag3_reg <= tag2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign result    = res3_reg;
    assign out_tag   = tag3_reg;
    assign inflight  = 2'({1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg});

endmodule
`default_nettype wire

// ===== hdl/ftfp_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfp_outq
// Result queue between the multiplier and the output channel.
// ----------------------------------------------------------------------------
module ftfp_outq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire ftfp_pkg::out_item_t           push_item,
    input  wire logic                          pop,
    output logic                               not_empty,
    output ftfp_pkg::out_item_t                head,
    output logic [ftfp_pkg::QCNT_W-1:0]        count
);
    import ftfp_pkg::*;

    out_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule
`default_nettype wire

// ===== hdl/force_torque_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// force_torque_frame_parser
// Finds fixed-length sensor frames in a byte stream and emits scaled channels.
// ----------------------------------------------------------------------------
// Bytes enter a row of byte cells that hold the last FRAME_LEN bytes (28 for
// six channels). When the oldest two cells hold 0x48 0xAA and the newest two
// hold 0x0D 0x0A, the payload is copied to a snapshot and the row is zeroed,
// so no byte serves two frames. While the queue has room, one channel a cycle
// then goes from the snapshot into a three-stage single-precision multiplier
// (scale register as second operand) and on into an eight-entry result queue.
// A byte is taken every cycle; the only stall is a byte that could complete
// a new frame while the previous frame's channels are still leaving the
// snapshot, which in turn waits for queue space. The first result goes
// through the three multiplier stages and the queue; results of one frame
// then follow one per cycle when the queue drains. The scale register takes
// writes at any cycle (cfg_ready is always high) and resets to 0x411CCCCD.
// ----------------------------------------------------------------------------
module force_torque_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] scale_factor,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       channel,
    output logic [31:0]      scaled_value,
    output logic             frame_last
);
    import ftfp_pkg::*;

    // scale register
    logic [31:0] scale_reg;

    // byte window
    logic [7:0]  win_q [FRAME_LEN];
    cell_ctrl_t  cell_ctrl;
    logic        accept;
    logic        frame_hit;
    logic        near_hit;

    // payload snapshot and channel sequencer
    logic [7:0]        snap_reg [PAYLOAD_LEN];
    logic              busy_reg, busy_next;
    logic [CH_W-1:0]   idx_reg, idx_next;
    logic [2:0]        chan_reg, chan_next;
    logic              issue;
    tag_t              issue_tag;

    // multiplier and queue
    logic              mul_valid;
    logic [31:0]       mul_result;
    tag_t              mul_tag;
    logic [1:0]        inflight;
    out_item_t         q_in;
    out_item_t         q_head;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W:0]   occupancy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            scale_reg <= scale_factor;
        end
    end

    // A frame closes on the byte being taken: oldest two bytes after the shift
    // are cells 1 and 2 now, newest two are cell FRAME_LEN-1 and the new byte.
    always_comb
    begin
        near_hit  = (win_q[1] == HDR0) && (win_q[2] == HDR1)
                 && (win_q[FRAME_LEN-1] == TRL0);
        // hold a possible frame close until the snapshot is free
        in_ready  = !(busy_reg && near_hit);
        accept    = in_valid && in_ready;
        frame_hit = accept && near_hit && (rx_byte == TRL1);
        cell_ctrl.shift = accept;
        cell_ctrl.clear = frame_hit;
    end

    for (genvar i = 0; i < FRAME_LEN; i++)
    begin : g_cell
        if (i == FRAME_LEN - 1)
        begin : g_tail
            ftfp_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (cell_ctrl),
                .d     (rx_byte),
                .q     (win_q[i])
            );
        end
        else
        begin : g_body
            ftfp_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (cell_ctrl),
                .d     (win_q[i+1]),
                .q     (win_q[i])
            );
        end
    end

    // issue one channel a cycle while the queue has room for all in flight
    always_comb
    begin
        occupancy = {1'b0, q_count} + (QCNT_W+1)'(inflight);
        issue     = busy_reg && (occupancy < (QCNT_W+1)'(QUEUE_DEPTH));
        issue_tag.channel = chan_reg;
        issue_tag.last    = (idx_reg == LAST_IDX);
        busy_next = busy_reg;
        idx_next  = idx_reg;
        chan_next = chan_reg;
        if (frame_hit)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            chan_next = 3'd0;
        end
        else if (issue)
        begin
            idx_next  = idx_reg + 1'b1;
            chan_next = chan_reg + 3'd1;
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            chan_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            chan_reg <= chan_next;
        end
    end

    // capture the payload on a frame, advance one word per issued channel
    for (genvar j = 0; j < PAYLOAD_LEN; j++)
    begin : g_snap
        if (j + 4 < PAYLOAD_LEN)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (frame_hit)
                begin
                    snap_reg[j] <= win_q[j+3];
                end
                else if (issue)
                begin
                    snap_reg[j] <= snap_reg[j+4];
                end
            end
        end
        else
        begin : g_end
            always_ff @(posedge clk)
            begin
                if (frame_hit)
                begin
                    snap_reg[j] <= win_q[j+3];
                end
            end
        end
    end

    ftfp_fmul u_fmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .a         ({snap_reg[3], snap_reg[2], snap_reg[1], snap_reg[0]}),
        .b         (scale_reg),
        .in_tag    (issue_tag),
        .out_valid (mul_valid),
        .result    (mul_result),
        .out_tag   (mul_tag),
        .inflight  (inflight)
    );

    always_comb
    begin
        q_in.channel = mul_tag.channel;
        q_in.value   = mul_result;
        q_in.last    = mul_tag.last;
    end

    ftfp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mul_valid),
        .push_item (q_in),
        .pop       (out_ready),
        .not_empty (out_valid),
        .head      (q_head),
        .count     (q_count)
    );

    assign channel      = q_head.channel;
    assign scaled_value = q_head.value;
    assign frame_last   = q_head.last;

endmodule
`default_nettype wire

// ===== hdl/ftfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ftfp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [2:0]  channel,
    input  wire logic [31:0] scaled_value,
    input  wire logic        frame_last
);
    import ftfp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scaled_value)
            && $stable(channel) && $stable(frame_last))
        else $error("stalled result changed");

    a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> channel == LAST_CHAN)
        else $error("frame_last on wrong channel");

    a_qnan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (scaled_value[30:23] == 8'hFF) && (scaled_value[22:0] != 23'd0)
            |-> scaled_value == QNAN_BITS)
        else $error("non-canonical NaN");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind force_torque_frame_parser ftfp_checker u_ftfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .channel      (channel),
    .scaled_value (scaled_value),
    .frame_last   (frame_last)
);
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the force/torque frame parser.
// ----------------------------------------------------------------------------
// A byte stream of whole frames, broken frames and noise is pushed into the
// parser, and the scale register is changed between phases. A scoreboard keeps
// its own 28-byte window and its own single-precision multiplier. It predicts
// the six scaled channels of every frame, and each result is checked against
// the oldest prediction. The sender works in bursts and the receiver stalls at
// random. One long receiver hold-off fills the result queue.
// ----------------------------------------------------------------------------
module tb;
    import ftfp_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts channel results from accepted bytes, checks outputs
    // ------------------------------------------------------------------------
    class ftfp_scoreboard;
        logic [7:0]  win [FRAME_LEN];
        logic [31:0] scale;
        out_item_t   pending_q [$];
        int          errors;

        function new();
            foreach (win[i]) win[i] = 8'h00;
            scale = SCALE_RESET;
            errors = 0;
        endfunction

        // Single-precision multiply, round to nearest even, subnormals kept,
        // every NaN folded to the canonical quiet NaN.
        static function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
            logic        sgn, grd, stk;
            logic [23:0] ma, mb;
            logic [24:0] keep;
            logic [47:0] m;
            int          ea, eb, e, sh;
            sgn = a[31] ^ b[31];
            if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
                return QNAN_BITS;
            if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
                // infinity times zero has no value
                if (a[30:0] == 0 || b[30:0] == 0)
                    return QNAN_BITS;
                return {sgn, 8'hFF, 23'd0};
            end
            if (a[30:0] == 0 || b[30:0] == 0)
                return {sgn, 31'd0};
            ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
            eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
            ma = {(a[30:23] != 0), a[22:0]};
            mb = {(b[30:23] != 0), b[22:0]};
            // bring subnormal operands up to a leading one
            while (!ma[23]) begin
                ma = ma << 1;
                ea--;
            end
            while (!mb[23]) begin
                mb = mb << 1;
                eb--;
            end
            m = ma * mb;
            e = ea + eb - 127;
            if (m[47])
                e++;
            else
                m = m << 1;
            // denormalize results below the normal range, keep a sticky bit
            if (e <= 0) begin
                sh = 1 - e;
                if (sh > 50) sh = 50;
                for (int i = 0; i < sh; i++)
                    m = {1'b0, m[47:2], m[1] | m[0]};
                e = 1;
            end
            keep = {1'b0, m[47:24]};
            grd  = m[23];
            stk  = |m[22:0];
            if (grd && (stk || keep[0]))
                keep = keep + 1;
            if (keep[24]) begin
                keep = keep >> 1;
                e++;
            end
            if (e >= 255)
                return {sgn, 8'hFF, 23'd0};
            return {sgn, keep[23] ? 8'(e) : 8'd0, keep[22:0]};
        endfunction

        // Shift one accepted byte into the window; on a frame, queue six results.
        function void note_byte(logic [7:0] b);
            out_item_t   r;
            logic [31:0] raw;
            for (int i = 0; i < FRAME_LEN - 1; i++)
                win[i] = win[i+1];
            win[FRAME_LEN-1] = b;
            if (win[0] != HDR0 || win[1] != HDR1 ||
                win[FRAME_LEN-2] != TRL0 || win[FRAME_LEN-1] != TRL1)
                return;
            for (int k = 0; k < CHANNELS; k++) begin
                raw = {win[5+4*k], win[4+4*k], win[3+4*k], win[2+4*k]};
                r.channel = 3'(k);
                r.value   = fmul(raw, scale);
                r.last    = (k == CHANNELS - 1);
                pending_q.insert(pending_q.size(), r);
            end
            foreach (win[i]) win[i] = 8'h00;
        endfunction

        function void check_result(logic [2:0] ch, logic [31:0] val, logic lst);
            out_item_t x;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: channel %0d value %h last %b", ch, val, lst);
                return;
            end
            x = pending_q[0];
            pending_q.delete(0);
            if (x.channel !== ch || x.value !== val || x.last !== lst) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected ch %0d val %h last %b, got ch %0d val %h last %b",
                             x.channel, x.value, x.last, ch, val, lst);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] scale_factor;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  channel;
    logic [31:0] scaled_value;
    logic        frame_last;

    ftfp_scoreboard sb;
    int  burst_left;
    int  bytes_sent;
    bit  hold_req;

    force_torque_frame_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .scale_factor (scale_factor),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .channel      (channel),
        .scaled_value (scaled_value),
        .frame_last   (frame_last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: stall at a rate that changes every so often; on request,
    // hold off for a long stretch so the result queue backs up into the input.
    initial
    begin
        int stall_pct;
        int seg;
        out_ready = 1'b0;
        stall_pct = 0;
        seg = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            if (seg == 0) begin
                seg = $urandom_range(80, 20);
                case ($urandom_range(3, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg--;
            out_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Check every result taken at a clock edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(channel, scaled_value, frame_last);
    end

    // Offer one byte; sit out a random gap whenever a burst runs out.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Pick one channel word, often a special IEEE pattern.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(11, 0))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return {$urandom_range(1, 0) == 1, 8'hFF, 23'd0};
            3: return {1'b0, 8'hFF, 23'($urandom_range(32'h7FFFFF, 1))};
            4: return {1'b1, 8'h00, 23'($urandom)};
            5: return {$urandom_range(1, 0) == 1, 31'h7F7F_FFFF};
            6: return {$urandom_range(1, 0) == 1, 8'($urandom_range(20, 1)), 23'($urandom)};
            7, 8: return {$urandom_range(1, 0) == 1,
                          8'($urandom_range(140, 115)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Send a frame with the given channel words; optionally spoil one marker.
    task automatic send_frame(input logic [31:0] w [CHANNELS], input bit spoil);
        logic [7:0] fb [FRAME_LEN];
        fb[0] = HDR0;
        fb[1] = HDR1;
        for (int k = 0; k < CHANNELS; k++)
            for (int j = 0; j < 4; j++)
                fb[2+4*k+j] = w[k][8*j +: 8];
        fb[FRAME_LEN-2] = TRL0;
        fb[FRAME_LEN-1] = TRL1;
        if (spoil) begin
            case ($urandom_range(3, 0))
                0: fb[0] = fb[0] ^ 8'(1 << $urandom_range(7, 0));
                1: fb[1] = fb[1] ^ 8'(1 << $urandom_range(7, 0));
                2: fb[FRAME_LEN-2] = fb[FRAME_LEN-2] ^ 8'(1 << $urandom_range(7, 0));
                default: fb[FRAME_LEN-1] = fb[FRAME_LEN-1] ^ 8'(1 << $urandom_range(7, 0));
            endcase
        end
        foreach (fb[i]) send_byte(fb[i]);
    endtask

    task automatic send_random_frame(input bit spoil);
        logic [31:0] w [CHANNELS];
        foreach (w[k]) w[k] = pick_word();
        send_frame(w, spoil);
    endtask

    // Hold the sender until every predicted result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_scale(input logic [31:0] v);
        drain();
        repeat (8) @(posedge clk);
        cfg_valid    <= 1'b1;
        scale_factor <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.scale = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int nbytes);
        int stop_at;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(3, 0) != 0)
                send_random_frame($urandom_range(6, 0) == 0);
            else
                repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        logic [31:0] w [CHANNELS];
        sb = new();
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        scale_factor = 32'h0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        burst_left   = 1;
        bytes_sent   = 0;
        hold_req     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme words with the reset scale.
        w[0] = 32'h0000_0000; w[1] = 32'h8000_0001; w[2] = 32'h7F80_0000;
        w[3] = 32'h7FFF_FFFF; w[4] = 32'h7F7F_FFFF; w[5] = 32'hFFFF_FFFF;
        send_frame(w, 1'b0);
        // Header bytes inside a frame's payload must not open a second frame.
        w[0] = 32'h0DAA_4848; w[1] = 32'h0A0D_AA48; w[2] = 32'h3F80_0000;
        w[3] = 32'hBF80_0000; w[4] = 32'h0080_0000; w[5] = 32'h0A0D_0A0D;
        send_frame(w, 1'b0);
        // A lone header, then a frame closing right after noise.
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(8'hFF);
        send_random_frame(1'b0);
        send_random_frame(1'b1);

        // Sender waits out the results, then the scale goes to its extremes.
        write_scale(32'h3F80_0000);
        random_phase(50);
        write_scale(32'h0000_0001);
        random_phase(30);
        write_scale(32'h7F7F_FFFF);
        random_phase(30);
        write_scale(32'hFFFF_FFFF);
        random_phase(20);
        write_scale(32'h0000_0000);
        random_phase(20);

        // Long receiver hold-off while frames keep arriving back to back.
        write_scale($urandom);
        hold_req = 1'b1;
        repeat (3) send_random_frame(1'b0);
        random_phase(20);

        write_scale(32'h411C_CCCD);
        random_phase(30);

        drain();
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ftfp_pkg.sv
hdl/ftfp_cell.sv
hdl/ftfp_fmul.sv
hdl/ftfp_outq.sv
hdl/force_torque_frame_parser.sv
hdl/ftfp_checker.sv
bench/tb.sv
